[rtl/core/gcs_pkg.sv]
`default_nettype none

package gcs_pkg;

  localparam int unsigned MaxKeyDigits = 16;
  localparam int unsigned DigitWidth   = 4;
  localparam int unsigned PosWidth     = 4;
  localparam int unsigned LenWidth     = 5;
  localparam int unsigned CodeWidth    = 16;
  localparam int unsigned CfgWidth     = 64;
  localparam int unsigned CfgIdxWidth  = 2;

  typedef logic [CodeWidth-1:0]  code_t;
  typedef logic [DigitWidth-1:0] digit_t;
  typedef logic [PosWidth-1:0]   pos_t;
  typedef logic [LenWidth-1:0]   len_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_KEY_DIGITS = 2'd0,
    REG_KEY_LENGTH = 2'd1,
    REG_DIRECTION  = 2'd2
  } cfg_reg_t;

  localparam code_t UpperFirst   = 16'd65;
  localparam code_t UpperLast    = 16'd90;
  localparam code_t LowerFirst   = 16'd97;
  localparam code_t LowerLast    = 16'd122;
  localparam code_t CyrUpperBase = 16'd192;
  localparam code_t CyrLowerBase = 16'd224;
  localparam code_t CyrLast      = 16'd255;

  localparam logic [5:0] LatinSpan    = 6'd26;
  localparam logic [5:0] CyrillicSpan = 6'd32;

endpackage

`default_nettype wire

[rtl/core/gcs_if.sv]
`default_nettype none

interface gcs_in_if import gcs_pkg::*; ();
  logic  valid;
  logic  ready;
  code_t char_code;
  logic  first_of_line;

  modport source (output valid, output char_code, output first_of_line, input ready);
  modport sink (input valid, input char_code, input first_of_line, output ready);
endinterface

interface gcs_out_if import gcs_pkg::*; ();
  logic  valid;
  logic  ready;
  code_t out_code;

  modport source (output valid, output out_code, input ready);
  modport sink (input valid, input out_code, output ready);
endinterface

`default_nettype wire

[rtl/core/gronsfeld_char_shift.sv]
// An accepted input enters the input register, then its result the result register.
// Throughput: one character per cycle; the key position counter and the two-stage
// pipeline (input register, result register) advance together whenever the output is free.
// Reset (rst, synchronous): key_digits 0, key_length 1, direction encrypt, key position 0,
// and both pipeline stages empty.
`default_nettype none

module gronsfeld_char_shift import gcs_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CfgIdxWidth-1:0] cfg_index,
  input  wire logic [CfgWidth-1:0]    cfg_wdata,
  gcs_in_if.sink                      in_ch,
  gcs_out_if.source                   out_ch
);

  logic [CfgWidth-1:0] key_digits;
  len_t                key_length;
  logic                direction;
  pos_t                key_position;

  // Stage one: captured character with its shift already selected.
  logic   v1;
  code_t  code1;
  digit_t shift1;
  logic   dir1;

  // Stage two: result register.
  logic  v2;
  code_t out_code;

  logic advance;
  logic in_accept;
  len_t len_eff;
  len_t pos_sel;
  len_t pos_inc;
  pos_t pos_next;
  digit_t shift_sel;
  code_t  result;

  function automatic logic is_letter(input code_t c);
    return ((c >= UpperFirst) && (c <= UpperLast)) ||
           ((c >= LowerFirst) && (c <= LowerLast)) ||
           ((c >= CyrUpperBase) && (c <= CyrLast));
  endfunction

  function automatic logic [4:0] wrap_off(input logic [4:0] off, input logic [5:0] span,
                                          input digit_t s, input logic dec);
    logic [5:0] t;
    t = dec ? ({1'b0, off} + span - {2'b00, s}) : ({1'b0, off} + {2'b00, s});
    if (t >= span) begin
      t = t - span;
    end
    return t[4:0];
  endfunction

  assign advance   = !v2 || out_ch.ready;
  assign in_ch.ready = advance;
  assign in_accept = in_ch.valid && advance;

  always_comb begin
    if (key_length == '0) begin
      len_eff = len_t'(1);
    end else if (key_length > len_t'(MaxKeyDigits)) begin
      len_eff = len_t'(MaxKeyDigits);
    end else begin
      len_eff = key_length;
    end
    pos_sel = in_ch.first_of_line ? '0 : {1'b0, key_position};
    if (pos_sel >= len_eff) begin
      pos_sel = '0;
    end
    shift_sel = key_digits[pos_sel[PosWidth-1:0]*DigitWidth +: DigitWidth];
    pos_inc   = pos_sel + len_t'(1);
    pos_next  = (pos_inc >= len_eff) ? '0 : pos_inc[PosWidth-1:0];
  end

  always_comb begin
    result = code1;
    if ((code1 >= UpperFirst) && (code1 <= UpperLast)) begin
      result = UpperFirst + code_t'(wrap_off(5'(code1 - UpperFirst), LatinSpan, shift1, dir1));
    end else if ((code1 >= LowerFirst) && (code1 <= LowerLast)) begin
      result = LowerFirst + code_t'(wrap_off(5'(code1 - LowerFirst), LatinSpan, shift1, dir1));
    end else if ((code1 >= CyrUpperBase) && (code1 < CyrLowerBase)) begin
      result = CyrUpperBase + code_t'(wrap_off(code1[4:0], CyrillicSpan, shift1, dir1));
    end else if ((code1 >= CyrLowerBase) && (code1 <= CyrLast)) begin
      result = CyrLowerBase + code_t'(wrap_off(code1[4:0], CyrillicSpan, shift1, dir1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_digits <= '0;
      key_length <= len_t'(1);
      direction  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_KEY_DIGITS: key_digits <= cfg_wdata;
        REG_KEY_LENGTH: key_length <= cfg_wdata[LenWidth-1:0];
        REG_DIRECTION:  direction  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_position <= '0;
      v1           <= 1'b0;
      v2           <= 1'b0;
    end else if (advance) begin
      v1 <= in_ch.valid;
      v2 <= v1;
      if (in_ch.valid) begin
        key_position <= pos_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      code1  <= in_ch.char_code;
      shift1 <= shift_sel;
      dir1   <= direction;
    end
    if (advance && v1) begin
      out_code <= result;
    end
  end

  assign out_ch.valid    = v2;
  assign out_ch.out_code = out_code;

  a_first_restarts: assert property (@(posedge clk) disable iff (rst)
    !rst && in_accept && in_ch.first_of_line |=>
      key_position == ((len_eff == len_t'(1)) ? pos_t'(0) : pos_t'(1)))
    else $error("key position did not restart on first character of line");

  a_passthrough: assert property (@(posedge clk) disable iff (rst)
    !rst && v1 && advance && !is_letter(code1) |=> out_code == $past(code1))
    else $error("non-letter code was altered");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    !rst && in_accept |=> v1)
    else $error("accepted transaction lost from first stage");

endmodule

`default_nettype wire

[tb/gcs_checker.sv]
`timescale 1ns / 100ps

module gcs_checker import gcs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CfgIdxWidth-1:0] cfg_index,
  input  logic [CfgWidth-1:0]    cfg_wdata,
  gcs_in_if                      in_mon,
  gcs_out_if                     out_mon,
  output int                     errors,
  output int                     pending,
  output int                     checked
);

  logic [CfgWidth-1:0] key_digits;
  len_t                key_len;
  logic                decrypting;
  pos_t                key_pos;
  code_t               expected_codes[$];

  function automatic code_t rotate(code_t c, code_t base, int span, int s);
    int off;
    off = c - base;
    off = decrypting ? off + span - s : off + s;
    if (off >= span) off -= span;
    return base + code_t'(off);
  endfunction

  // Works out the ciphered character and moves the key position along.
  function automatic code_t shift_char(code_t c, logic fl);
    int    len;
    int    pos;
    int    s;
    code_t r;
    len = (key_len == 0) ? 1 : (key_len > MaxKeyDigits) ? MaxKeyDigits : key_len;
    pos = fl ? 0 : key_pos;
    // A position left over from a longer key falls back to the first digit.
    if (pos >= len) pos = 0;
    s = key_digits[DigitWidth*pos +: DigitWidth];
    r = c;
    if (c >= UpperFirst && c <= UpperLast) begin
      r = rotate(c, UpperFirst, LatinSpan, s);
    end else if (c >= LowerFirst && c <= LowerLast) begin
      r = rotate(c, LowerFirst, LatinSpan, s);
    end else if (c >= CyrUpperBase && c < CyrLowerBase) begin
      r = rotate(c, CyrUpperBase, CyrillicSpan, s);
    end else if (c >= CyrLowerBase && c <= CyrLast) begin
      r = rotate(c, CyrLowerBase, CyrillicSpan, s);
    end
    key_pos = pos_t'((pos + 1 >= len) ? 0 : pos + 1);
    return r;
  endfunction

  always @(posedge clk) begin
    code_t want;
    if (rst) begin
      key_digits = '0;
      key_len    = 1;
      decrypting = 1'b0;
      key_pos    = '0;
      expected_codes.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_KEY_DIGITS: key_digits = cfg_wdata;
          REG_KEY_LENGTH: key_len = cfg_wdata[LenWidth-1:0];
          REG_DIRECTION: decrypting = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_codes.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("Unexpected output transaction: out_code 0x%04h", out_mon.out_code);
        end else begin
          want = expected_codes.pop_front();
          checked++;
          if (out_mon.out_code !== want) begin
            errors++;
            if (errors <= 10)
              $display("Mismatch on result %0d: expected 0x%04h, got 0x%04h",
                       checked, want, out_mon.out_code);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_codes.push_back(shift_char(in_mon.char_code, in_mon.first_of_line));
    end
    pending <= expected_codes.size();
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import gcs_pkg::*;

  localparam int ResetCycles   = 6;
  localparam int CycleLimit    = 600000;
  localparam int RandomPhases  = 8;
  localparam int CharsPerPhase = 180;
  localparam int HoldAt        = 420;
  localparam int HoldCycles    = 300;

  localparam code_t BoundaryCodes[17] = '{
    UpperLast, UpperLast, LowerLast, 16'd223, CyrLast, 16'd64, 16'd91, 16'd96,
    16'd123, 16'd191, 16'd32, 16'd0, 16'hFFFF, 16'd256, CyrUpperBase, CyrLowerBase,
    UpperFirst
  };

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CfgIdxWidth-1:0] cfg_index;
  logic [CfgWidth-1:0]    cfg_wdata;
  int                     errors;
  int                     pending;
  int                     checked;
  int                     sent = 0;
  bit                     steady = 1'b0;
  bit                     held = 1'b0;

  gcs_in_if  in_ch();
  gcs_out_if out_ch();

  gronsfeld_char_shift dut (
    .clk,
    .rst,
    .cfg_we,
    .cfg_index,
    .cfg_wdata,
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  gcs_checker shift_check (
    .clk,
    .rst,
    .cfg_we,
    .cfg_index,
    .cfg_wdata,
    .in_mon  (in_ch),
    .out_mon (out_ch),
    .errors,
    .pending,
    .checked
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_char(code_t c, logic fl);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.char_code     <= c;
    in_ch.first_of_line <= fl;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  // Drops valid and waits for every outstanding result to come back.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_key(logic [CfgWidth-1:0] digits, logic [CfgWidth-1:0] len_word,
                           logic [CfgWidth-1:0] dir_word);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_KEY_DIGITS;
    cfg_wdata <= digits;
    @(posedge clk);
    cfg_index <= REG_KEY_LENGTH;
    cfg_wdata <= len_word;
    @(posedge clk);
    cfg_index <= REG_DIRECTION;
    cfg_wdata <= dir_word;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int                  n;
    int                  line_len;
    int                  r;
    int                  len;
    code_t               c;
    logic                fl;
    logic [CfgWidth-1:0] digits;
    logic [CfgWidth-1:0] len_word;
    logic [CfgWidth-1:0] dir_word;
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= REG_KEY_DIGITS;
    cfg_wdata           <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.char_code     <= '0;
    in_ch.first_of_line <= 1'b0;
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The reset key is a single zero digit, so letters pass through.
    send_char(UpperFirst, 1'b1);
    send_char(CyrLast, 1'b0);
    settle();

    write_key(64'hFEDC_BA98_7654_3210, 64'd16, 64'd0);
    foreach (BoundaryCodes[i]) send_char(BoundaryCodes[i], i == 0);
    settle();

    // Length zero acts as one digit, and the stale position must fall back to zero.
    write_key(64'h0000_0000_0000_00F9, 64'd0, 64'd1);
    send_char(UpperFirst, 1'b0);
    send_char(LowerFirst, 1'b0);
    send_char(CyrUpperBase, 1'b0);
    send_char(CyrLowerBase, 1'b0);

    for (int p = 0; p < RandomPhases; p++) begin
      settle();
      case (p)
        0: write_key(64'h9999_9999_9999_9999, 64'd31, 64'd1);
        1: write_key('0, 64'd1, 64'd0);
        2: write_key('1, 64'd16, 64'd0);
        default: begin
          for (int i = 0; i < MaxKeyDigits; i++)
            digits[DigitWidth*i +: DigitWidth] =
              ($urandom_range(3) == 0) ? digit_t'($urandom) : digit_t'($urandom_range(9));
          r = $urandom_range(9);
          len = (r < 7) ? $urandom_range(1, 16) : (r == 7) ? 0 :
                (r == 8) ? $urandom_range(17, 31) : 16;
          len_word = {$urandom, $urandom};
          len_word[LenWidth-1:0] = len_t'(len);
          dir_word = {$urandom, $urandom};
          write_key(digits, len_word, dir_word);
        end
      endcase
      steady = (p == 1 || p == 5);
      n = 0;
      while (n < CharsPerPhase) begin
        line_len = $urandom_range(1, 40);
        for (int k = 0; k < line_len && n < CharsPerPhase; k++) begin
          r = $urandom_range(99);
          if (r < 35) c = UpperFirst + code_t'($urandom_range(25));
          else if (r < 60) c = LowerFirst + code_t'($urandom_range(25));
          else if (r < 72) c = CyrUpperBase + code_t'($urandom_range(31));
          else if (r < 84) c = CyrLowerBase + code_t'($urandom_range(31));
          else if (r < 90) c = 16'd32;
          else if (r < 95) c = code_t'($urandom_range(255));
          else c = code_t'($urandom);
          // The first line of a phase sometimes continues the old position.
          fl = (k == 0 && (n > 0 || $urandom_range(1) == 1)) || $urandom_range(49) == 0;
          send_char(c, fl);
          n++;
        end
      end
    end

    settle();
    repeat (10) @(posedge clk);
    $display("Sent %0d characters under %0d key settings; %0d results compared.",
             sent, RandomPhases + 3, checked);
    $display("Both cipher directions, key lengths 0 to 31 and a %0d-cycle output stall seen.",
             HoldCycles);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off while the sender keeps offering.
  initial begin
    int run;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && sent >= HoldAt) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      run = pick_gap();
      if (run > 0) begin
        out_ch.ready <= 1'b0;
        repeat (run) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      run = ($urandom_range(9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
      repeat (run) @(posedge clk);
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles, %0d results outstanding.", cycles, pending);
    $display("Verification failed");
    $finish;
  end

endmodule
